// ===== rtl/core/maau_pkg.sv =====
// Shared types and constants for the modular arithmetic unit.
`default_nettype none

package maau_pkg;

   // Data width of the modulus, the operands and the result.
   localparam int WIDTH = 63;
   // Counter width for stepping through the bits of one value.
   localparam int CNT_W = $clog2(WIDTH);
   // Width of the internal sums, with room for a carry and a sign.
   localparam int SUM_W = WIDTH + 2;
   // Stream data widths, rounded up to whole bytes.
   localparam int REQ_TDATA_W = ((2 * WIDTH + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((WIDTH + 7) / 8) * 8;

   // Operation codes carried in the request tuser.
   typedef enum logic [1:0] {
      FN_ADD = 2'd0,
      FN_SUB = 2'd1,
      FN_MUL = 2'd2,
      FN_DIV = 2'd3
   } func_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RED_X,
      ST_RED_Y,
      ST_DISPATCH,
      ST_EU_CHECK,
      ST_EU_DIV,
      ST_EU_DBL,
      ST_EU_ACC,
      ST_EU_UPD,
      ST_MUL_DBL,
      ST_MUL_ACC,
      ST_DONE
   } state_type;

   // Operand set handed to the shared add/subtract unit.
   typedef struct packed {
      logic [WIDTH-1:0] a;
      logic [WIDTH-1:0] b;
      logic [WIDTH-1:0] m;
      logic             cin;
      logic             sub;
   } alu_req_type;

   // Reduced result of the shared unit and its wrap flag.
   typedef struct packed {
      logic [WIDTH-1:0] res;
      logic             ge;
   } alu_rsp_type;

   // One operation handed from the top level to the sequencer.
   typedef struct packed {
      func_type         func;
      logic [WIDTH-1:0] x;
      logic [WIDTH-1:0] y;
      logic [WIDTH-1:0] n;
   } seq_cmd_type;

   // Sequencer status toward the top level.
   typedef struct packed {
      logic idle;
      logic done;
   } seq_stat_type;

   // Finished result of one operation.
   typedef struct packed {
      logic [WIDTH-1:0] result;
      logic             no_inverse;
   } seq_rsp_type;

endpackage

`default_nettype wire

// ===== rtl/core/maau_alu.sv =====
// Shared modular add/subtract unit used by every arithmetic step of the sequencer.
`default_nettype none

module maau_alu
   import maau_pkg::*;
(
   input  alu_req_type req,
   output alu_rsp_type rsp
);

   logic [SUM_W-1:0] a_ext;
   logic [SUM_W-1:0] b_ext;
   logic [SUM_W-1:0] m_ext;
   logic [SUM_W-1:0] sum;
   logic [SUM_W-1:0] fixed;
   logic             ge;

   // Raw sum or difference, with the carry-in for shift-in steps.
   always_comb begin
      a_ext = SUM_W'(req.a);
      b_ext = SUM_W'(req.b);
      m_ext = SUM_W'(req.m);
      if (req.sub) begin
         sum = a_ext - b_ext;
      end else begin
         sum = a_ext + b_ext + SUM_W'(req.cin);
      end
   end

   // Bring the value back into 0..m-1: one correction is enough since
   // both inputs are already below m.
   always_comb begin
      if (req.sub) begin
         ge    = 1'b0;
         fixed = sum[SUM_W-1] ? sum + m_ext : sum;
      end else begin
         ge    = (sum >= m_ext);
         fixed = ge ? sum - m_ext : sum;
      end
   end

   assign rsp.res = fixed[WIDTH-1:0];
   assign rsp.ge  = ge;

endmodule

`default_nettype wire

// ===== rtl/core/maau_seq.sv =====
// Sequencer that runs reduction, multiply and extended Euclid on the shared unit.
`default_nettype none

module maau_seq
   import maau_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  seq_cmd_type  cmd,
   input  logic         ack,
   output seq_stat_type stat,
   output seq_rsp_type  rsp
);

   state_type        state_ff, state_in;
   func_type         func_ff, func_in;
   logic [WIDTH-1:0] n_ff, n_in;
   logic [WIDTH-1:0] x_ff, x_in;
   logic [WIDTH-1:0] y_ff, y_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] m_ff, m_in;
   logic [WIDTH-1:0] r0_ff, r0_in;
   logic [WIDTH-1:0] r1_ff, r1_in;
   logic [WIDTH-1:0] t0_ff, t0_in;
   logic [WIDTH-1:0] t1_ff, t1_in;
   logic [WIDTH-1:0] mb_ff, mb_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             qbit_ff, qbit_in;
   logic             flag_ff, flag_in;

   alu_req_type      alu_req;
   alu_rsp_type      alu_rsp;

   localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(WIDTH - 1);

   maau_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      func_ff <= func_in;
      n_ff    <= n_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      acc_ff  <= acc_in;
      m_ff    <= m_in;
      r0_ff   <= r0_in;
      r1_ff   <= r1_in;
      t0_ff   <= t0_in;
      t1_ff   <= t1_in;
      mb_ff   <= mb_in;
      cnt_ff  <= cnt_in;
      qbit_ff <= qbit_in;
      flag_ff <= flag_in;
   end

   // Next state, next datapath values and the shared unit's operands.
   always_comb begin
      state_in = state_ff;
      func_in  = func_ff;
      n_in     = n_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      acc_in   = acc_ff;
      m_in     = m_ff;
      r0_in    = r0_ff;
      r1_in    = r1_ff;
      t0_in    = t0_ff;
      t1_in    = t1_ff;
      mb_in    = mb_ff;
      cnt_in   = cnt_ff;
      qbit_in  = qbit_ff;
      flag_in  = flag_ff;
      alu_req  = '0;
      alu_req.m = n_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               func_in  = cmd.func;
               n_in     = cmd.n;
               x_in     = cmd.x;
               y_in     = cmd.y;
               acc_in   = '0;
               cnt_in   = CNT_TOP;
               flag_in  = 1'b0;
               state_in = ST_RED_X;
            end
         end

         // Reduce x mod n one bit a cycle, MSB first.
         ST_RED_X: begin
            alu_req.a   = acc_ff;
            alu_req.b   = acc_ff;
            alu_req.cin = x_ff[cnt_ff];
            acc_in      = alu_rsp.res;
            cnt_in      = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               x_in     = alu_rsp.res;
               acc_in   = '0;
               cnt_in   = CNT_TOP;
               state_in = ST_RED_Y;
            end
         end

         // Reduce y mod n the same way.
         ST_RED_Y: begin
            alu_req.a   = acc_ff;
            alu_req.b   = acc_ff;
            alu_req.cin = y_ff[cnt_ff];
            acc_in      = alu_rsp.res;
            cnt_in      = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               y_in     = alu_rsp.res;
               acc_in   = '0;
               cnt_in   = CNT_TOP;
               state_in = ST_DISPATCH;
            end
         end

         ST_DISPATCH: begin
            alu_req.a = x_ff;
            alu_req.b = y_ff;
            case (func_ff)
               FN_ADD: begin
                  acc_in   = alu_rsp.res;
                  state_in = ST_DONE;
               end
               FN_SUB: begin
                  alu_req.sub = 1'b1;
                  acc_in      = alu_rsp.res;
                  state_in    = ST_DONE;
               end
               FN_MUL: begin
                  mb_in    = y_ff;
                  acc_in   = '0;
                  cnt_in   = CNT_TOP;
                  state_in = ST_MUL_DBL;
               end
               FN_DIV: begin
                  r0_in    = n_ff;
                  r1_in    = y_ff;
                  t0_in    = '0;
                  t1_in    = (n_ff == WIDTH'(1)) ? '0 : WIDTH'(1);
                  state_in = ST_EU_CHECK;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end

         // End of Euclid when the remainder runs out; otherwise start the next division.
         ST_EU_CHECK: begin
            if (r1_ff == '0) begin
               if (r0_ff == WIDTH'(1)) begin
                  mb_in    = t0_ff;
                  acc_in   = '0;
                  cnt_in   = CNT_TOP;
                  state_in = ST_MUL_DBL;
               end else begin
                  acc_in   = '0;
                  flag_in  = 1'b1;
                  state_in = ST_DONE;
               end
            end else begin
               acc_in   = '0;
               m_in     = '0;
               cnt_in   = CNT_TOP;
               state_in = ST_EU_DIV;
            end
         end

         // One restoring division bit of r0 / r1.
         ST_EU_DIV: begin
            alu_req.a   = acc_ff;
            alu_req.b   = acc_ff;
            alu_req.cin = r0_ff[cnt_ff];
            alu_req.m   = r1_ff;
            acc_in      = alu_rsp.res;
            qbit_in     = alu_rsp.ge;
            state_in    = ST_EU_DBL;
         end

         // Running q * t1 mod n: double for each quotient bit.
         ST_EU_DBL: begin
            alu_req.a = m_ff;
            alu_req.b = m_ff;
            m_in      = alu_rsp.res;
            if (qbit_ff) begin
               state_in = ST_EU_ACC;
            end else if (cnt_ff == '0) begin
               state_in = ST_EU_UPD;
            end else begin
               cnt_in   = cnt_ff - CNT_W'(1);
               state_in = ST_EU_DIV;
            end
         end

         // Add t1 where the quotient bit is set.
         ST_EU_ACC: begin
            alu_req.a = m_ff;
            alu_req.b = t1_ff;
            m_in      = alu_rsp.res;
            if (cnt_ff == '0) begin
               state_in = ST_EU_UPD;
            end else begin
               cnt_in   = cnt_ff - CNT_W'(1);
               state_in = ST_EU_DIV;
            end
         end

         // Shift the remainder and coefficient pairs.
         ST_EU_UPD: begin
            alu_req.a   = t0_ff;
            alu_req.b   = m_ff;
            alu_req.sub = 1'b1;
            r0_in       = r1_ff;
            r1_in       = acc_ff;
            t0_in       = t1_ff;
            t1_in       = alu_rsp.res;
            state_in    = ST_EU_CHECK;
         end

         // Shift-add multiply of x by mb: double step.
         ST_MUL_DBL: begin
            alu_req.a = acc_ff;
            alu_req.b = acc_ff;
            acc_in    = alu_rsp.res;
            if (mb_ff[cnt_ff]) begin
               state_in = ST_MUL_ACC;
            end else if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end

         // Shift-add multiply: add x.
         ST_MUL_ACC: begin
            alu_req.a = acc_ff;
            alu_req.b = x_ff;
            acc_in    = alu_rsp.res;
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               cnt_in   = cnt_ff - CNT_W'(1);
               state_in = ST_MUL_DBL;
            end
         end

         ST_DONE: begin
            if (ack) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign stat.idle       = (state_ff == ST_IDLE);
   assign stat.done       = (state_ff == ST_DONE);
   assign rsp.result      = acc_ff;
   assign rsp.no_inverse  = flag_ff;

   // A missing inverse is only reported for divide, and then with a zero result.
   a_flag_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && flag_ff) |-> (func_ff == FN_DIV && acc_ff == '0))
      else $error("no_inverse set outside divide or with nonzero result");

   // Every finished result is a residue below the modulus.
   a_res_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (acc_ff < n_ff))
      else $error("result not reduced below modulus");

   // Euclid remainders stay ordered.
   a_eu_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EU_DIV) |-> (r1_ff != '0 && r1_ff <= r0_ff))
      else $error("Euclid divisor zero or above dividend");

   // A new operation only starts from idle.
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      (start && state_ff == ST_IDLE) |=> (state_ff == ST_RED_X))
      else $error("start did not launch the reduction");

endmodule

`default_nettype wire

// ===== rtl/core/modular_arithmetic_unit_top.sv =====
// Top level of the modular arithmetic unit: stream ports, modulus register, result register.
//
// Usage:
//   The csr channel (csr_valid, csr_ready, csr_data) writes the modulus n; csr_ready is
//   always high. Write it only while the block is idle. A modulus of zero acts as one.
//   The req channel carries one operation per transfer: tuser holds the operation code
//   (add, subtract, multiply, divide), tdata the operands x and y. The rsp channel
//   returns one transfer per operation: tdata holds the residue, tuser the no-inverse flag.
//   Sequence: the operands x and y are first reduced mod n bit-serially, one after the
//   other, then dispatched. Add and subtract finish in the dispatch step. Multiply runs
//   a double step for every multiplier bit and an add step for every set bit. Divide runs
//   extended Euclid: each Euclid step divides the remainders bit-serially, with a double
//   step per dividend bit and an add step per set quotient bit, then an update; y's inverse
//   is then multiplied by x. All steps share the single modular add/subtract unit.
//   One operation is in flight at a time; req_tready is high only while the sequencer is
//   idle, so a new operation may enter while the previous result still waits in rsp.
//   If the receiver stalls, the finished operation waits in the sequencer until the
//   result register frees up. Reset sets the modulus to 1 and empties the result register.
`default_nettype none

module modular_arithmetic_unit_top
   import maau_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // Configuration write: modulus.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [WIDTH-1:0]       csr_data,
   // Requests.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // operand_x, operand_y, zero pad
   input  logic [1:0]             req_tuser,  // func
   // Results.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // result, zero pad
   output logic [0:0]             rsp_tuser   // no_inverse
);

   logic [WIDTH-1:0] modulus_ff, modulus_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [WIDTH-1:0] rsp_data_ff, rsp_data_in;
   logic             rsp_flag_ff, rsp_flag_in;

   seq_cmd_type      cmd;
   seq_stat_type     stat;
   seq_rsp_type      seq_rsp;
   logic             start;
   logic             ack;

   // Modulus register, written by a csr transfer.
   assign csr_ready  = 1'b1;
   assign modulus_in = (csr_valid && csr_ready) ? csr_data : modulus_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= WIDTH'(1);
      end else begin
         modulus_ff <= modulus_in;
      end
   end

   // Request unpacking; a zero modulus acts as one.
   always_comb begin
      cmd.func = func_type'(req_tuser);
      cmd.x    = req_tdata[WIDTH-1:0];
      cmd.y    = req_tdata[2*WIDTH-1:WIDTH];
      cmd.n    = (modulus_ff == '0) ? WIDTH'(1) : modulus_ff;
   end

   assign req_tready = stat.idle;
   assign start      = req_tvalid && req_tready;

   maau_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .cmd   (cmd),
      .ack   (ack),
      .stat  (stat),
      .rsp   (seq_rsp)
   );

   // Result register: loads when the sequencer is done and the slot is free.
   assign ack = stat.done && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_flag_in  = rsp_flag_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (ack) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = seq_rsp.result;
         rsp_flag_in  = seq_rsp.no_inverse;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_flag_ff <= rsp_flag_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = RSP_TDATA_W'(rsp_data_ff);
   assign rsp_tuser[0] = rsp_flag_ff;

endmodule

`default_nettype wire
